FILE: hdl/srtcm_pkg.sv
`default_nettype none

package srtcm_pkg;

  // Default sizes of the timestamp and the bucket levels.
  localparam int TIME_BITS_DEFAULT        = 32;
  localparam int BUCKET_BYTE_BITS_DEFAULT = 24;
  localparam int FRACTION_BITS_DEFAULT    = 16;

  // Fixed widths of the ports.
  localparam int ARRIVAL_W   = 32;
  localparam int LENGTH_W    = 16;
  localparam int RATE_W      = 32;
  localparam int BURST_W     = 24;
  localparam int COLOR_W     = 2;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_COMMITTED_RATE  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_COMMITTED_BURST = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_EXCESS_BURST    = 2'd2;

  // Meter result codes.
  typedef enum logic [COLOR_W-1:0] {
    COLOR_GREEN  = 2'd0,
    COLOR_YELLOW = 2'd1,
    COLOR_RED    = 2'd2
  } color_t;

endpackage

`default_nettype wire

FILE: hdl/single_rate_three_color_meter.sv
// Single-rate three-color meter with a committed and an excess token bucket.
// Each item carries an arrival timestamp in ticks and a packet length in bytes
// and yields one color: green, yellow or red. The block takes one item every
// clock cycle unless the output holds it off; the color comes from the bucket
// stage, which sets the sustained rate and refills, compares and debits both
// bucket levels together. Ahead of it, one stage forms the elapsed ticks and
// one holds the rate multiplier with its saturation. A stage advances when it
// is empty or its successor advances, so new items are still taken while a
// color waits at the output, until the stages fill. Configuration is taken in
// every cycle and must only be written while no item is in flight.
`default_nettype none

module single_rate_three_color_meter
  import srtcm_pkg::*;
#(
  parameter int TIME_BITS        = TIME_BITS_DEFAULT,
  parameter int BUCKET_BYTE_BITS = BUCKET_BYTE_BITS_DEFAULT,
  parameter int FRACTION_BITS    = FRACTION_BITS_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [ARRIVAL_W-1:0]   arrival_time,
  input  wire logic [LENGTH_W-1:0]    packet_length,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic      [COLOR_W-1:0]     color
);

  localparam int LEVEL_BITS = BUCKET_BYTE_BITS + FRACTION_BITS;

  logic [RATE_W-1:0]     committed_rate;
  logic [LEVEL_BITS-1:0] committed_cap;
  logic [LEVEL_BITS-1:0] excess_cap;
  logic [LEVEL_BITS-1:0] refill;
  logic [LENGTH_W-1:0]   refill_length;
  color_t                color_result;

  logic in_stage_valid;
  logic mul_stage_valid;
  logic out_stage_valid;
  logic in_stage_adv;
  logic mul_stage_adv;
  logic out_stage_adv;

  assign cfg_ready = 1'b1;

  // A stage moves on when it is empty or its successor moves on.
  assign out_stage_adv = !out_stage_valid || out_ready;
  assign mul_stage_adv = !mul_stage_valid || out_stage_adv;
  assign in_stage_adv  = !in_stage_valid || mul_stage_adv;
  assign in_ready      = in_stage_adv;
  assign out_valid     = out_stage_valid;
  assign color         = color_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_stage_valid  <= 1'b0;
      mul_stage_valid <= 1'b0;
      out_stage_valid <= 1'b0;
    end else begin
      if (in_stage_adv) begin
        in_stage_valid <= in_valid;
      end
      if (mul_stage_adv) begin
        mul_stage_valid <= in_stage_valid;
      end
      if (out_stage_adv) begin
        out_stage_valid <= mul_stage_valid;
      end
    end
  end

  srtcm_cfg #(
    .BUCKET_BYTE_BITS (BUCKET_BYTE_BITS),
    .FRACTION_BITS    (FRACTION_BITS)
  ) u_cfg (
    .clk            (clk),
    .rst            (rst),
    .write_en       (cfg_valid && cfg_ready),
    .write_index    (cfg_index),
    .write_data     (cfg_data),
    .committed_rate (committed_rate),
    .committed_cap  (committed_cap),
    .excess_cap     (excess_cap)
  );

  srtcm_refill #(
    .TIME_BITS        (TIME_BITS),
    .BUCKET_BYTE_BITS (BUCKET_BYTE_BITS),
    .FRACTION_BITS    (FRACTION_BITS)
  ) u_refill (
    .clk            (clk),
    .rst            (rst),
    .load_in        (in_valid && in_ready),
    .load_mul       (in_stage_valid && mul_stage_adv),
    .arrival_time   (arrival_time),
    .packet_length  (packet_length),
    .committed_rate (committed_rate),
    .refill         (refill),
    .refill_length  (refill_length)
  );

  srtcm_bucket #(
    .BUCKET_BYTE_BITS (BUCKET_BYTE_BITS),
    .FRACTION_BITS    (FRACTION_BITS)
  ) u_bucket (
    .clk           (clk),
    .rst           (rst),
    .load          (mul_stage_valid && out_stage_adv),
    .refill        (refill),
    .packet_length (refill_length),
    .committed_cap (committed_cap),
    .excess_cap    (excess_cap),
    .color         (color_result)
  );

endmodule

`default_nettype wire

FILE: hdl/srtcm_cfg.sv
`default_nettype none

module srtcm_cfg
  import srtcm_pkg::*;
#(
  parameter int BUCKET_BYTE_BITS = BUCKET_BYTE_BITS_DEFAULT,
  parameter int FRACTION_BITS    = FRACTION_BITS_DEFAULT
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  input  wire logic                                      write_en,
  input  wire logic [CFG_INDEX_W-1:0]                    write_index,
  input  wire logic [CFG_DATA_W-1:0]                     write_data,
  output logic      [RATE_W-1:0]                         committed_rate,
  output logic      [BUCKET_BYTE_BITS+FRACTION_BITS-1:0] committed_cap,
  output logic      [BUCKET_BYTE_BITS+FRACTION_BITS-1:0] excess_cap
);

  localparam int LEVEL_BITS = BUCKET_BYTE_BITS + FRACTION_BITS;
  localparam int SHIFT_W    = (BURST_W + FRACTION_BITS > LEVEL_BITS) ?
                              BURST_W + FRACTION_BITS : LEVEL_BITS + 1;

  logic [BURST_W-1:0] committed_burst;
  logic [BURST_W-1:0] excess_burst;

  // Scales a burst in bytes to fixed point, limited to the largest level.
  function automatic logic [LEVEL_BITS-1:0] burst_cap(input logic [BURST_W-1:0] bytes);
    logic [SHIFT_W-1:0] fixed;
    fixed = SHIFT_W'(bytes) << FRACTION_BITS;
    if (fixed[SHIFT_W-1:LEVEL_BITS] != '0) begin
      burst_cap = '1;
    end else begin
      burst_cap = fixed[LEVEL_BITS-1:0];
    end
  endfunction

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      committed_rate  <= '0;
      committed_burst <= '0;
      excess_burst    <= '0;
    end else if (write_en) begin
      unique case (write_index)
        CFG_COMMITTED_RATE:  committed_rate  <= write_data[RATE_W-1:0];
        CFG_COMMITTED_BURST: committed_burst <= write_data[BURST_W-1:0];
        CFG_EXCESS_BURST:    excess_burst    <= write_data[BURST_W-1:0];
        default: ;
      endcase
    end
  end

  // Bucket capacities in fixed point, kept registered off the bucket loop.
  always_ff @(posedge clk) begin
    if (rst) begin
      committed_cap <= '0;
      excess_cap    <= '0;
    end else begin
      committed_cap <= burst_cap(committed_burst);
      excess_cap    <= burst_cap(excess_burst);
    end
  end

endmodule

`default_nettype wire

FILE: hdl/srtcm_refill.sv
`default_nettype none

module srtcm_refill
  import srtcm_pkg::*;
#(
  parameter int TIME_BITS        = TIME_BITS_DEFAULT,
  parameter int BUCKET_BYTE_BITS = BUCKET_BYTE_BITS_DEFAULT,
  parameter int FRACTION_BITS    = FRACTION_BITS_DEFAULT
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  input  wire logic                                      load_in,
  input  wire logic                                      load_mul,
  input  wire logic [ARRIVAL_W-1:0]                      arrival_time,
  input  wire logic [LENGTH_W-1:0]                       packet_length,
  input  wire logic [RATE_W-1:0]                         committed_rate,
  output logic      [BUCKET_BYTE_BITS+FRACTION_BITS-1:0] refill,
  output logic      [LENGTH_W-1:0]                       refill_length
);

  localparam int LEVEL_BITS = BUCKET_BYTE_BITS + FRACTION_BITS;
  localparam int PROD_W     = TIME_BITS + RATE_W;
  localparam int SAT_W      = (PROD_W > LEVEL_BITS) ? PROD_W : LEVEL_BITS + 1;

  logic [TIME_BITS-1:0] now;
  logic [TIME_BITS-1:0] last_arrival;
  logic [TIME_BITS-1:0] ticks;
  logic [LENGTH_W-1:0]  in_length;
  logic [PROD_W-1:0]    product;
  logic [SAT_W-1:0]     product_ext;
  logic [LEVEL_BITS-1:0] refill_next;

  assign now = TIME_BITS'(arrival_time);

  // Input stage: elapsed ticks wrap with the timestamp width.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_arrival <= '0;
    end else if (load_in) begin
      last_arrival <= now;
    end
  end

  always_ff @(posedge clk) begin
    if (load_in) begin
      ticks     <= now - last_arrival;
      in_length <= packet_length;
    end
  end

  // Refill amount, saturated at the largest bucket level.
  assign product     = PROD_W'(ticks) * PROD_W'(committed_rate);
  assign product_ext = SAT_W'(product);

  always_comb begin
    if (product_ext[SAT_W-1:LEVEL_BITS] != '0) begin
      refill_next = '1;
    end else begin
      refill_next = product_ext[LEVEL_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load_mul) begin
      refill        <= refill_next;
      refill_length <= in_length;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/srtcm_bucket.sv
`default_nettype none

module srtcm_bucket
  import srtcm_pkg::*;
#(
  parameter int BUCKET_BYTE_BITS = BUCKET_BYTE_BITS_DEFAULT,
  parameter int FRACTION_BITS    = FRACTION_BITS_DEFAULT
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  input  wire logic                                      load,
  input  wire logic [BUCKET_BYTE_BITS+FRACTION_BITS-1:0] refill,
  input  wire logic [LENGTH_W-1:0]                       packet_length,
  input  wire logic [BUCKET_BYTE_BITS+FRACTION_BITS-1:0] committed_cap,
  input  wire logic [BUCKET_BYTE_BITS+FRACTION_BITS-1:0] excess_cap,
  output color_t                                         color
);

  localparam int LEVEL_BITS = BUCKET_BYTE_BITS + FRACTION_BITS;

  logic [LEVEL_BITS-1:0] committed_level;
  logic [LEVEL_BITS-1:0] excess_level;
  logic [LEVEL_BITS-1:0] committed_level_next;
  logic [LEVEL_BITS-1:0] excess_level_next;
  color_t                color_next;

  logic [LEVEL_BITS:0]   total;
  logic [LEVEL_BITS:0]   spill;
  logic [LEVEL_BITS+1:0] excess_sum;
  logic [LEVEL_BITS-1:0] committed_filled;
  logic [LEVEL_BITS-1:0] excess_filled;
  logic [LEVEL_BITS-1:0] length_fixed;

  assign length_fixed = LEVEL_BITS'(packet_length) << FRACTION_BITS;

  // Refill: the committed bucket fills first and its overflow goes to the
  // excess bucket.
  always_comb begin
    total      = (LEVEL_BITS + 1)'(committed_level) + (LEVEL_BITS + 1)'(refill);
    spill      = total - (LEVEL_BITS + 1)'(committed_cap);
    excess_sum = (LEVEL_BITS + 2)'(excess_level) + (LEVEL_BITS + 2)'(spill);
    if (total >= (LEVEL_BITS + 1)'(committed_cap)) begin
      committed_filled = committed_cap;
      if (excess_sum >= (LEVEL_BITS + 2)'(excess_cap)) begin
        excess_filled = excess_cap;
      end else begin
        excess_filled = excess_sum[LEVEL_BITS-1:0];
      end
    end else begin
      committed_filled = total[LEVEL_BITS-1:0];
      excess_filled    = excess_level;
    end
  end

  // Coloring: debit the committed bucket, else the excess bucket, else none.
  always_comb begin
    committed_level_next = committed_filled;
    excess_level_next    = excess_filled;
    if (committed_filled >= length_fixed) begin
      committed_level_next = committed_filled - length_fixed;
      color_next           = COLOR_GREEN;
    end else if (excess_filled >= length_fixed) begin
      excess_level_next = excess_filled - length_fixed;
      color_next        = COLOR_YELLOW;
    end else begin
      color_next = COLOR_RED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      committed_level <= '0;
      excess_level    <= '0;
    end else if (load) begin
      committed_level <= committed_level_next;
      excess_level    <= excess_level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      color <= color_next;
    end
  end

endmodule

`default_nettype wire

FILE: tb/sv/tb_single_rate_three_color_meter.sv
`timescale 1ns / 100ps

module tb_single_rate_three_color_meter;
  import srtcm_pkg::*;

  localparam int CLK_HALF_NS = 4;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 6;
  localparam int LONG_STALL_CYCLES = 400;
  localparam int RANDOM_PHASES = 12;
  localparam int PACKETS_PER_PHASE = 125;

  // Index that maps to no register; writes to it must change nothing.
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

  // Largest bucket level in Q24.16.
  localparam logic [63:0] LEVEL_TOP = (64'd1 << 40) - 64'd1;

  typedef struct packed {
    logic [ARRIVAL_W-1:0] arrival;
    logic [LENGTH_W-1:0]  length;
  } packet_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [ARRIVAL_W-1:0]   arrival_time = '0;
  logic [LENGTH_W-1:0]    packet_length = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [COLOR_W-1:0]     color;

  single_rate_three_color_meter dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .arrival_time (arrival_time),
    .packet_length(packet_length),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .color        (color)
  );

  always #CLK_HALF_NS clk = ~clk;

  // Packets waiting to be offered and colors waiting to come out.
  packet_t packet_queue[$];
  color_t  expected_colors[$];

  // Shadow copy of the meter registers and bucket state.
  logic [RATE_W-1:0]    cir_q16 = '0;
  logic [BURST_W-1:0]   cbs_bytes = '0;
  logic [BURST_W-1:0]   ebs_bytes = '0;
  logic [39:0]          commit_tokens;
  logic [39:0]          excess_tokens;
  logic [ARRIVAL_W-1:0] prev_arrival;

  int error_count = 0;
  int packets_sent = 0;
  int cfg_writes = 0;
  int green_seen = 0;
  int yellow_seen = 0;
  int red_seen = 0;
  int send_idle_pct = 6;
  int recv_idle_pct = 72;
  int stall_left = 0;
  int quiet_cycles = 0;
  bit stall_request = 1'b0;
  bit in_fire = 1'b0;
  logic [ARRIVAL_W-1:0] stim_time = '0;

  // Burst register in whole bytes scaled to a bucket level, saturated.
  function automatic logic [63:0] burst_level(input logic [BURST_W-1:0] bytes);
    logic [63:0] scaled;
    scaled = 64'(bytes) << 16;
    return (scaled > LEVEL_TOP) ? LEVEL_TOP : scaled;
  endfunction

  // Refill both buckets for the elapsed ticks, then color and debit.
  function automatic color_t meter_packet(input logic [ARRIVAL_W-1:0] t,
                                          input logic [LENGTH_W-1:0] len);
    logic [ARRIVAL_W-1:0] elapsed;
    logic [63:0] ticks;
    logic [63:0] fill;
    logic [63:0] cap_c;
    logic [63:0] cap_e;
    logic [63:0] total;
    logic [63:0] sum_e;
    logic [63:0] need;
    color_t      c;
    // The difference wraps at the timestamp width before it is widened.
    elapsed = t - prev_arrival;
    ticks = 64'(elapsed);
    if (cir_q16 != 0 && ticks > LEVEL_TOP / 64'(cir_q16)) begin
      fill = LEVEL_TOP;
    end else begin
      fill = ticks * 64'(cir_q16);
      if (fill > LEVEL_TOP) begin
        fill = LEVEL_TOP;
      end
    end
    cap_c = burst_level(cbs_bytes);
    cap_e = burst_level(ebs_bytes);
    total = 64'(commit_tokens) + fill;
    prev_arrival = t;
    if (total >= cap_c) begin
      sum_e = 64'(excess_tokens) + (total - cap_c);
      commit_tokens = cap_c[39:0];
      excess_tokens = (sum_e >= cap_e) ? cap_e[39:0] : sum_e[39:0];
    end else begin
      commit_tokens = total[39:0];
    end
    need = 64'(len) << 16;
    if (64'(commit_tokens) >= need) begin
      commit_tokens = commit_tokens - need[39:0];
      c = COLOR_GREEN;
    end else if (64'(excess_tokens) >= need) begin
      excess_tokens = excess_tokens - need[39:0];
      c = COLOR_YELLOW;
    end else begin
      c = COLOR_RED;
    end
    return c;
  endfunction

  // Input driver: offers the next queued packet once the previous item is taken.
  always @(negedge clk) begin
    packet_t nxt;
    if (!in_valid || in_fire) begin
      if (packet_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = packet_queue.pop_front();
        in_valid <= 1'b1;
        arrival_time <= nxt.arrival;
        packet_length <= nxt.length;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output back-pressure, with an occasional long hold-off on request.
  always @(negedge clk) begin
    if (stall_request) begin
      stall_left = LONG_STALL_CYCLES;
      stall_request = 1'b0;
    end
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Monitor: predicts each accepted packet and checks each delivered color.
  always @(posedge clk) begin
    color_t want;
    if (rst) begin
      in_fire = 1'b0;
      commit_tokens = '0;
      excess_tokens = '0;
      prev_arrival = '0;
    end else begin
      in_fire = in_valid && in_ready;
      if (in_fire) begin
        expected_colors.push_back(meter_packet(arrival_time, packet_length));
        packets_sent++;
      end
      if (out_valid && out_ready) begin
        if (expected_colors.size() == 0) begin
          $display("%0t: unexpected color, expected none, got %0d", $time, color);
          error_count++;
        end else begin
          want = expected_colors.pop_front();
          if (color !== want) begin
            $display("%0t: color mismatch, expected %0d, got %0d", $time, want, color);
            error_count++;
          end
          case (want)
            COLOR_GREEN:  green_seen++;
            COLOR_YELLOW: yellow_seen++;
            default:      red_seen++;
          endcase
        end
      end
    end
  end

  // Watchdog on cycles in which no channel moves an item.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_COMMITTED_RATE:  cir_q16 = data;
      CFG_COMMITTED_BURST: cbs_bytes = data[BURST_W-1:0];
      CFG_EXCESS_BURST:    ebs_bytes = data[BURST_W-1:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(input logic [31:0] rate, input logic [31:0] cbs,
                           input logic [31:0] ebs);
    write_reg(CFG_COMMITTED_RATE, rate);
    write_reg(CFG_COMMITTED_BURST, cbs);
    write_reg(CFG_EXCESS_BURST, ebs);
    @(posedge clk);
  endtask

  task automatic add_packet(input logic [ARRIVAL_W-1:0] t, input logic [LENGTH_W-1:0] len);
    packet_t p;
    p.arrival = t;
    p.length = len;
    packet_queue.push_back(p);
  endtask

  // Blocks until every queued packet is taken and every color has come out.
  task automatic wait_drained();
    while (packet_queue.size() != 0 || in_valid || expected_colors.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly steady traffic with small gaps, mixed with stamps that jump,
  // go backwards or are fully random, and with extreme lengths.
  task automatic queue_random_packets(input int count);
    int roll;
    logic [LENGTH_W-1:0] len;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      len = LENGTH_W'((($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                                   : $urandom_range(0, 1600)));
      if (roll < 70) begin
        stim_time = stim_time + $urandom_range(0, 40);
      end else if (roll < 80) begin
        stim_time = stim_time + $urandom_range(0, 2000);
      end else if (roll < 85) begin
        len = '0;
      end else if (roll < 90) begin
        stim_time = stim_time - $urandom_range(1, 1000);
      end else if (roll < 95) begin
        stim_time = $urandom;
        len = LENGTH_W'($urandom);
      end else begin
        stim_time = stim_time + $urandom_range(0, 8);
        len = LENGTH_W'(16'hFFFF - $urandom_range(0, 3));
      end
      add_packet(stim_time, len);
    end
  endtask

  function automatic logic [31:0] pick_rate();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(32'h0001_0000, 32'h0050_0000);
    else if (roll < 80) return 32'd0;
    else if (roll < 90) return 32'hFFFF_FFFF;
    else return $urandom;
  endfunction

  // Burst values in the random case carry junk above bit 23 on purpose.
  function automatic logic [31:0] pick_burst();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(0, 6000);
    else if (roll < 80) return 32'd0;
    else if (roll < 90) return 32'h00FF_FFFF;
    else return $urandom;
  endfunction

  initial begin
    logic [31:0] new_rate;
    logic [31:0] new_cbs;
    logic [31:0] new_ebs;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Registers at reset: zero length is green, anything else is red.
    add_packet(32'h0000_0000, 16'h0000);
    add_packet(32'h0000_0000, 16'h0001);
    add_packet(32'hFFFF_FFFF, 16'hFFFF);
    wait_drained();

    // Full rate: a backwards stamp reads as a long interval and the refill
    // product saturates; the excess bucket fills to its burst.
    configure(32'hFFFF_FFFF, 32'd4000, 32'h00FF_FFFF);
    add_packet(32'hFFFF_FFFE, 16'h0000);
    add_packet(32'hFFFF_FFFE, 16'd3000);
    wait_drained();

    // Excess burst lowered below its level: left alone while the committed
    // bucket does not overflow.
    configure(32'd0, 32'd4000, 32'd100);
    add_packet(32'hFFFF_FFFF, 16'd5000);
    add_packet(32'h0000_0000, 16'd800);
    wait_drained();

    // Committed burst lowered below its level: the surplus spills over and
    // the excess bucket is clamped.
    configure(32'd0, 32'd150, 32'd100);
    add_packet(32'h0000_0000, 16'd180);
    add_packet(32'h0000_0000, 16'd100);
    add_packet(32'h0000_0000, 16'd100);
    add_packet(32'h0000_0000, 16'd1);
    add_packet(32'h0000_0000, 16'd60);
    wait_drained();

    // One byte per tick with the largest bursts.
    configure(32'h0001_0000, 32'h00FF_FFFF, 32'h00FF_FFFF);
    add_packet(32'h8000_0000, 16'hFFFF);
    add_packet(32'h8000_0000, 16'h5555);
    add_packet(32'h8000_0001, 16'hAAAA);
    add_packet(32'h8000_0002, 16'h0001);
    add_packet(32'h7FFF_FFFF, 16'h8000);
    wait_drained();

    // A write to the spare index must leave the meter unchanged.
    write_reg(CFG_UNUSED_INDEX, $urandom);
    @(posedge clk);
    add_packet(32'h8000_0003, 16'h0000);
    wait_drained();

    stim_time = $urandom;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p < 4) begin
        send_idle_pct = 6;
        recv_idle_pct = 72;
      end else if (p < 8) begin
        send_idle_pct = 72;
        recv_idle_pct = 6;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      new_rate = pick_rate();
      new_cbs = pick_burst();
      new_ebs = pick_burst();
      case (p)
        0: begin
          new_rate = $urandom_range(32'h0001_0000, 32'h0050_0000);
          new_cbs = $urandom_range(0, 6000);
          new_ebs = $urandom_range(0, 6000);
        end
        1: begin
          new_rate = 32'd0;
          new_cbs = 32'h00FF_FFFF;
          new_ebs = 32'h00FF_FFFF;
        end
        2: begin
          new_rate = 32'hFFFF_FFFF;
          new_cbs = 32'd0;
          new_ebs = 32'd0;
        end
        3: begin
          new_cbs = 32'd0;
          new_ebs = 32'h00FF_FFFF;
        end
        4: begin
          new_cbs = 32'h00FF_FFFF;
          new_ebs = 32'd0;
        end
        default: ;
      endcase
      configure(new_rate, new_cbs, new_ebs);
      if (p == 6) begin
        write_reg(CFG_UNUSED_INDEX, $urandom);
        @(posedge clk);
      end
      queue_random_packets(PACKETS_PER_PHASE);
      // Hold the output off long enough for the pipeline to back up.
      if (p == 3) begin
        stall_request = 1'b1;
      end
      wait_drained();
    end

    $display("Metered %0d packets across %0d register writes and %0d random settings.",
             packets_sent, cfg_writes, RANDOM_PHASES);
    $display("Colors checked: %0d green, %0d yellow, %0d red; %0d errors.",
             green_seen, yellow_seen, red_seen, error_count);
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/srtcm_pkg.sv
hdl/srtcm_cfg.sv
hdl/srtcm_refill.sv
hdl/srtcm_bucket.sv
hdl/single_rate_three_color_meter.sv
tb/sv/tb_single_rate_three_color_meter.sv
